@@ design/multipath_rtt_path_selector_unit_macros.svh @@
// Assertion macros for the multipath RTT path selector.
`ifndef MULTIPATH_RTT_PATH_SELECTOR_UNIT_MACROS_SVH
`define MULTIPATH_RTT_PATH_SELECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define MRPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MRPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define MRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ design/mrps_pkg.sv @@
// Package: shared constants and types of the multipath RTT path selector.
`timescale 1ns / 1ps
package mrps_pkg;

    localparam int DEF_PATH_ID_WIDTH = 8;
    localparam int DEF_RTT_WIDTH     = 32;

    // Why a path was chosen.
    typedef enum logic [1:0] {
        REASON_NONE = 2'd0,
        REASON_SRTT = 2'd1,
        REASON_LINK = 2'd2
    } t_reason;

endpackage

@@ design/mrps_stream_if.sv @@
// Interfaces: candidate path request channel and selection result channel.
`timescale 1ns / 1ps
interface mrps_path_if #(
    parameter int PATH_ID_WIDTH = mrps_pkg::DEF_PATH_ID_WIDTH,
    parameter int RTT_WIDTH     = mrps_pkg::DEF_RTT_WIDTH
);
    logic                     valid;
    logic                     ready;
    logic [PATH_ID_WIDTH-1:0] path_id;
    logic                     usable;
    logic                     send_ok;
    logic [RTT_WIDTH-1:0]     smoothed_rtt_us;
    logic [RTT_WIDTH-1:0]     link_rtt_us;
    logic                     reinject;
    logic [PATH_ID_WIDTH-1:0] packet_path_id;
    logic                     require_other_path;
    logic                     last_path;

    modport source (
        output valid, path_id, usable, send_ok, smoothed_rtt_us, link_rtt_us,
               reinject, packet_path_id, require_other_path, last_path,
        input  ready
    );
    modport sink (
        input  valid, path_id, usable, send_ok, smoothed_rtt_us, link_rtt_us,
               reinject, packet_path_id, require_other_path, last_path,
        output ready
    );
endinterface

interface mrps_result_if #(
    parameter int PATH_ID_WIDTH = mrps_pkg::DEF_PATH_ID_WIDTH
);
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [PATH_ID_WIDTH-1:0] chosen_path;
    logic [1:0]               reason;
    logic                     congestion_blocked;

    modport source (
        output valid, found, chosen_path, reason, congestion_blocked,
        input  ready
    );
    modport sink (
        input  valid, found, chosen_path, reason, congestion_blocked,
        output ready
    );
endinterface

@@ design/mrps_best_cmp.sv @@
// Candidate-versus-running-best comparator of the path selector.
`timescale 1ns / 1ps
module mrps_best_cmp #(
    parameter int RTT_WIDTH = mrps_pkg::DEF_RTT_WIDTH
) (
    input  logic                 i_have_best,
    input  logic [RTT_WIDTH-1:0] i_top_srtt,
    input  logic [RTT_WIDTH-1:0] i_best_link,
    input  logic [RTT_WIDTH-1:0] i_srtt,
    input  logic [RTT_WIDTH-1:0] i_link,
    output logic                 o_beats
);
    import mrps_pkg::*;

    logic cand_known;
    logic best_known;

    assign cand_known = |i_link;
    assign best_known = |i_best_link;

    always_comb begin
        if (!i_have_best) begin
            o_beats = 1'b1;
        end else if (cand_known && best_known && (i_link != i_best_link)) begin
            o_beats = i_link < i_best_link;
        end else if (cand_known && !best_known) begin
            o_beats = 1'b1;
        end else if (!cand_known && best_known) begin
            o_beats = 1'b0;
        end else begin
            // equal or both unknown link RTT: earlier path keeps ties
            o_beats = i_srtt < i_top_srtt;
        end
    end

endmodule

@@ design/multipath_rtt_path_selector_unit.sv @@
// Top level: minimum-RTT multipath path selector with link-RTT preference.
//
//  channel    | dir | carries                                   | accepted when
//  -----------+-----+-------------------------------------------+----------------------
//  i_path     | in  | one candidate path plus packet flags      | valid && ready
//  o_result   | out | found, selected path, reason, cong. block | valid && ready
//
//  One candidate request is taken every cycle unless a last-path request is held;
//  the input register feeds the compare against the running best, which updates
//  at the next edge. A result is registered in the output register after its last
//  request passes the input register. A pending result holds a last-path request in
//  the input register, and new requests stall behind it until the result is taken.
//  Reset is synchronous, active low, and clears the running best and both
//  valid flags; after each result the running best returns to that state.
`timescale 1ns / 1ps
module multipath_rtt_path_selector_unit #(
    parameter int PATH_ID_WIDTH = mrps_pkg::DEF_PATH_ID_WIDTH,
    parameter int RTT_WIDTH     = mrps_pkg::DEF_RTT_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mrps_path_if.sink     i_path,
    mrps_result_if.source o_result
);
    import mrps_pkg::*;

`include "multipath_rtt_path_selector_unit_macros.svh"

    // input register
    logic                     r_in_valid;
    logic [PATH_ID_WIDTH-1:0] r_in_id;
    logic                     r_in_usable;
    logic                     r_in_send_ok;
    logic [RTT_WIDTH-1:0]     r_in_srtt;
    logic [RTT_WIDTH-1:0]     r_in_link;
    logic                     r_in_reinject;
    logic [PATH_ID_WIDTH-1:0] r_in_pkt_path;
    logic                     r_in_req_other;
    logic                     r_in_last;

    // running best
    logic                     r_have_best,  n_have_best;
    logic [PATH_ID_WIDTH-1:0] r_best_id,    n_best_id;
    logic [RTT_WIDTH-1:0]     r_top_srtt,   n_top_srtt;
    logic [RTT_WIDTH-1:0]     r_best_link,  n_best_link;
    logic                     r_have_orig,  n_have_orig;
    logic [PATH_ID_WIDTH-1:0] r_orig_id,    n_orig_id;
    logic                     r_seen_usable, n_seen_usable;
    logic                     r_any_send_ok, n_any_send_ok;

    // result register
    logic                     r_out_valid;
    logic                     r_found,  n_found;
    logic [PATH_ID_WIDTH-1:0] r_sel_id, n_sel_id;
    t_reason                  r_reason, n_reason;
    logic                     r_cong,   n_cong;

    logic out_free;
    logic advance;
    logic in_take;
    logic cand_ok;
    logic is_orig;
    logic beats;

    assign out_free = !r_out_valid || o_result.ready;
    assign advance  = r_in_valid && (!r_in_last || out_free);
    assign i_path.ready = !r_in_valid || advance;
    assign in_take  = i_path.valid && i_path.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_path.ready) begin
            r_in_valid <= i_path.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_id        <= i_path.path_id;
            r_in_usable    <= i_path.usable;
            r_in_send_ok   <= i_path.send_ok;
            r_in_srtt      <= i_path.smoothed_rtt_us;
            r_in_link      <= i_path.link_rtt_us;
            r_in_reinject  <= i_path.reinject;
            r_in_pkt_path  <= i_path.packet_path_id;
            r_in_req_other <= i_path.require_other_path;
            r_in_last      <= i_path.last_path;
        end
    end

    mrps_best_cmp #(
        .RTT_WIDTH (RTT_WIDTH)
    ) u_best_cmp (
        .i_have_best (r_have_best),
        .i_top_srtt  (r_top_srtt),
        .i_best_link (r_best_link),
        .i_srtt      (r_in_srtt),
        .i_link      (r_in_link),
        .o_beats     (beats)
    );

    assign cand_ok = r_in_usable && r_in_send_ok;
    assign is_orig = r_in_reinject && (r_in_pkt_path == r_in_id);

    always_comb begin
        n_have_best    = r_have_best;
        n_best_id      = r_best_id;
        n_top_srtt     = r_top_srtt;
        n_best_link    = r_best_link;
        n_have_orig    = r_have_orig;
        n_orig_id      = r_orig_id;
        n_seen_usable  = r_seen_usable || r_in_usable;
        n_any_send_ok  = r_any_send_ok || cand_ok;

        if (cand_ok && is_orig) begin
            n_have_orig = 1'b1;
            n_orig_id   = r_in_id;
        end else if (cand_ok && beats) begin
            n_have_best = 1'b1;
            n_best_id   = r_in_id;
            n_top_srtt  = r_in_srtt;
            n_best_link = r_in_link;
        end

        n_found  = 1'b0;
        n_sel_id = '0;
        n_reason = REASON_NONE;
        if (n_have_best) begin
            n_found  = 1'b1;
            n_sel_id = n_best_id;
            n_reason = (|n_best_link) ? REASON_LINK : REASON_SRTT;
        end else if (n_have_orig && !r_in_req_other) begin
            n_found  = 1'b1;
            n_sel_id = n_orig_id;
            n_reason = REASON_SRTT;
        end
        n_cong = n_seen_usable && !n_any_send_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            // clear the decision state on reset and after each result
            r_have_best    <= 1'b0;
            r_best_id      <= '0;
            r_top_srtt     <= '1;
            r_best_link    <= '0;
            r_have_orig    <= 1'b0;
            r_orig_id      <= '0;
            r_seen_usable  <= 1'b0;
            r_any_send_ok  <= 1'b0;
        end else if (advance) begin
            r_have_best    <= n_have_best;
            r_best_id      <= n_best_id;
            r_top_srtt     <= n_top_srtt;
            r_best_link    <= n_best_link;
            r_have_orig    <= n_have_orig;
            r_orig_id      <= n_orig_id;
            r_seen_usable  <= n_seen_usable;
            r_any_send_ok  <= n_any_send_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_found  <= n_found;
            r_sel_id <= n_sel_id;
            r_reason <= n_reason;
            r_cong   <= n_cong;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.found              = r_found;
    assign o_result.chosen_path        = r_sel_id;
    assign o_result.reason             = r_reason;
    assign o_result.congestion_blocked = r_cong;

    `MRPS_ASSERT_NOW(a_found_has_reason, i_clk, i_rst_n, r_out_valid && r_found,
        r_reason != REASON_NONE, "found result without a reason")
    `MRPS_ASSERT_NOW(a_none_is_zero, i_clk, i_rst_n, r_out_valid && !r_found,
        (r_sel_id == '0) && (r_reason == REASON_NONE), "empty result not zeroed")
    `MRPS_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, advance && r_in_last,
        !r_have_best && !r_have_orig && !r_seen_usable && r_out_valid,
        "decision state not cleared after last path")
    `MRPS_ASSERT_NOW(a_send_implies_usable, i_clk, i_rst_n, r_any_send_ok,
        r_seen_usable, "sendable path seen without a usable path")
    `MRPS_ASSERT_NOW(a_best_implies_send, i_clk, i_rst_n, r_have_best || r_have_orig,
        r_any_send_ok, "candidate held without any sendable path")

endmodule
